// File: design/pscf_pkg.sv
package pscf_pkg;

  // field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SR_W       = 18;
  localparam int unsigned FREQ_W     = 19;
  localparam int unsigned DIVIDEND_W = SR_W + 4;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  // op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PLUCK  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] REG_DECAY       = 2'd1;
  localparam logic [1:0] REG_LEVEL       = 2'd2;
  localparam logic [1:0] REG_AMPLITUDE   = 2'd3;

  // register reset values
  localparam logic [SR_W-1:0]   SAMPLE_RATE_RST = 18'd44100;
  localparam logic [GAIN_W-1:0] DECAY_RST       = 16'd64881;
  localparam logic [GAIN_W-1:0] LEVEL_RST       = 16'd0;
  localparam logic [GAIN_W-1:0] AMPLITUDE_RST   = 16'd65535;

  // loop filter weights, 0.7 and 0.3 in Q1.15
  localparam logic signed [15:0] W_DELAYED = 16'sd22938;
  localparam logic signed [15:0] W_PREV    = 16'sd9830;

  // noise generator
  localparam logic [31:0] LFSR_SEED = 32'h1234_5678;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLAMP,
    ST_FILL,
    ST_RD,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_OUT
  } pscf_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic clamp;
    logic fill_step;
    logic rd;
    logic f1;
    logic f2;
    logic f3;
    logic f4;
    logic out_load;
  } pscf_cmd_t;

  typedef struct packed {
    logic div_last;
    logic fill_last;
    logic out_busy;
  } pscf_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [19:0] x);
    logic signed [15:0] r;
    if (x > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

// File: design/pscf_ram.sv
module pscf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/pscf_ctrl.sv
module pscf_ctrl
  import pscf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_op_i,
  output logic         in_ready_o,
  input  pscf_status_t status_i,
  output pscf_cmd_t    cmd_o
);

  pscf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == OP_PLUCK) ? ST_DIV : ST_RD;
        end
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: state_d = ST_FILL;
      ST_FILL: begin
        if (status_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD:  state_d = ST_F1;
      ST_F1:  state_d = ST_F2;
      ST_F2:  state_d = ST_F3;
      ST_F3:  state_d = ST_F4;
      ST_F4:  state_d = ST_OUT;
      ST_OUT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV:   cmd_o.div_step  = 1'b1;
      ST_CLAMP: cmd_o.clamp     = 1'b1;
      ST_FILL:  cmd_o.fill_step = 1'b1;
      ST_RD:    cmd_o.rd        = 1'b1;
      ST_F1:    cmd_o.f1        = 1'b1;
      ST_F2:    cmd_o.f2        = 1'b1;
      ST_F3:    cmd_o.f3        = 1'b1;
      ST_F4:    cmd_o.f4        = 1'b1;
      ST_OUT:   cmd_o.out_load  = !status_i.out_busy;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: design/pscf_dp.sv
module pscf_dp
  import pscf_pkg::*;
#(
  parameter int unsigned MAX_DELAY = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pscf_cmd_t                  cmd_i,
  output pscf_status_t               status_o,
  input  logic [SR_W-1:0]            sample_rate_i,
  input  logic [GAIN_W-1:0]          decay_i,
  input  logic [GAIN_W-1:0]          level_i,
  input  logic [GAIN_W-1:0]          amplitude_i,
  input  logic signed [SAMPLE_W-1:0] excite_i,
  input  logic signed [SAMPLE_W-1:0] mix_i,
  input  logic [FREQ_W-1:0]          freq_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [SAMPLE_W-1:0]        out_sample_o
);

  localparam int unsigned AW = $clog2(MAX_DELAY);

  // held item
  logic signed [SAMPLE_W-1:0] excite_q, mix_q;
  logic [FREQ_W-1:0]          freq_q;

  // divider
  logic [DIVIDEND_W-1:0] div_quo_q;
  logic [FREQ_W-1:0]     div_rem_q;
  logic [DIV_CNT_W-1:0]  div_cnt_q;
  logic [FREQ_W:0]       rem_sh;
  logic [FREQ_W+1:0]     rem_diff;
  logic                  rem_ge;

  // pluck fill
  logic [AW-1:0] len_new_q;
  logic [AW-1:0] fill_cnt_q;
  logic [31:0]   lfsr_q;
  logic [31:0]   lfsr_next;
  logic          fill_last;

  // voice state
  logic [AW-1:0]              idx_q;
  logic [AW-1:0]              len_q;
  logic [AW:0]                hwm_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic [AW:0]                idx_inc;

  // arithmetic pipeline
  logic signed [SAMPLE_W-1:0] tap, tap_q;
  logic signed [31:0]         pa_q, pb_q, fsum;
  logic signed [SAMPLE_W-1:0] filt_q;
  logic signed [16:0]         fbsum;
  logic signed [33:0]         fb_prod_q, fb_rnd;
  logic signed [32:0]         v1_q;
  logic signed [49:0]         v2_q, v2_rnd;
  logic signed [SAMPLE_W-1:0] fb_sat;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_valid_q;

  // delay store port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;

  // restoring divide step
  assign rem_sh   = {div_rem_q, div_quo_q[DIVIDEND_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, freq_q};
  assign rem_ge   = !rem_diff[FREQ_W+1];

  assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);
  assign fill_last = (fill_cnt_q == (len_new_q - AW'(1)));
  assign idx_inc   = {1'b0, idx_q} + (AW+1)'(1);

  // entries past the fill mark were never written and read as zero
  assign tap    = ({1'b0, idx_q} < hwm_q) ? $signed(ram_rdata) : '0;
  assign fsum   = pa_q + pb_q + 32'sd16384;
  assign fbsum  = 17'(filt_q) + 17'(excite_q);
  assign fb_rnd = fb_prod_q + 34'sd32768;
  assign fb_sat = sat16(20'($signed(fb_rnd[33:16])));
  assign v2_rnd = v2_q + 50'sd2147483648;

  assign ram_we    = cmd_i.fill_step || cmd_i.f4;
  assign ram_waddr = cmd_i.fill_step ? fill_cnt_q : idx_q;
  assign ram_wdata = cmd_i.fill_step ? lfsr_next[31:16] : fb_sat;

  pscf_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_DELAY)
  ) u_delay_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q   <= '0;
      fill_cnt_q  <= '0;
      lfsr_q      <= LFSR_SEED;
      idx_q       <= '0;
      len_q       <= AW'(1);
      hwm_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.clamp) begin
        fill_cnt_q <= '0;
      end else if (cmd_i.fill_step) begin
        fill_cnt_q <= fill_cnt_q + AW'(1);
        lfsr_q     <= lfsr_next;
        if (fill_last) begin
          len_q  <= len_new_q;
          idx_q  <= '0;
          prev_q <= '0;
          if ({1'b0, len_new_q} > hwm_q) begin
            hwm_q <= {1'b0, len_new_q};
          end
        end
      end
      if (cmd_i.f4) begin
        idx_q  <= (idx_inc >= {1'b0, len_q}) ? '0 : idx_inc[AW-1:0];
        prev_q <= tap_q;
        if ({1'b0, idx_q} >= hwm_q) begin
          hwm_q <= idx_inc;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      excite_q  <= excite_i;
      mix_q     <= mix_i;
      freq_q    <= freq_i;
      div_quo_q <= {sample_rate_i, 4'b0000};
      div_rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_quo_q <= {div_quo_q[DIVIDEND_W-2:0], rem_ge};
      div_rem_q <= rem_ge ? rem_diff[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
    end
    if (cmd_i.clamp) begin
      if ({1'b0, div_quo_q} >= (DIVIDEND_W+1)'(MAX_DELAY)) begin
        len_new_q <= AW'(MAX_DELAY - 1);
      end else if (div_quo_q == '0) begin
        len_new_q <= AW'(1);
      end else begin
        len_new_q <= div_quo_q[AW-1:0];
      end
    end
    if (cmd_i.f1) begin
      tap_q <= tap;
      pa_q  <= tap * W_DELAYED;
      pb_q  <= prev_q * W_PREV;
    end
    if (cmd_i.f2) begin
      filt_q <= fsum[30:15];
    end
    if (cmd_i.f3) begin
      fb_prod_q <= fbsum * $signed({1'b0, decay_i});
      v1_q      <= filt_q * $signed({1'b0, level_i});
    end
    if (cmd_i.f4) begin
      v2_q <= v1_q * $signed({1'b0, amplitude_i});
    end
    if (cmd_i.out_load) begin
      out_q <= sat16(20'(mix_q) + 20'($signed(v2_rnd[49:32])));
    end
  end

  assign status_o.div_last  = (div_cnt_q == DIV_LAST);
  assign status_o.fill_last = fill_last;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

endmodule

// File: design/plucked_string_comb_filter.sv
// Plucked-string voice (Karplus-Strong style), Q1.15 samples. Each input
// transaction carries an op in tuser: a sample transaction (op 0) reads the
// delayed tap, low-passes it against the previous tap (0.7/0.3), writes
// (filtered + excite) * decay back with saturation, and returns one output
// transaction mix_in + filtered * level * amplitude, saturated. A pluck
// transaction (op 1) returns nothing; it divides sample_rate*16 by
// frequency_q4 to get the delay length (clamped to 1..MAX_DELAY-1), fills
// that many entries with LFSR noise and restarts the read index.
// Timing: between accepts a sample runs one memory read, four arithmetic
// steps and one output load, stretched only while the output register still
// holds an untaken result. A pluck runs a 22-step restoring divider, a clamp
// step, then one delay-memory write per entry. The delay memory is one
// single-port-write RAM; a fill mark tracks how far it has been written
// since reset and entries beyond it read as zero, so there is no clearing
// pass after reset. A new input transaction is taken while an earlier
// result still waits on the output side. Configuration is by APB:
// sample_rate at 0x0, decay at 0x4, level at 0x8, amplitude at 0xC; write
// only while the block is idle.
module plucked_string_comb_filter
  import pscf_pkg::*;
#(
  parameter int unsigned MAX_DELAY = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // excite_in[15:0], mix_in[31:16], frequency_q4[50:32]
  input  logic        s_axis_tuser,  // op[0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_sample[15:0]
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SR_W-1:0]   sample_rate_q;
  logic [GAIN_W-1:0] decay_q, level_q, amplitude_q;
  logic              cfg_we;

  pscf_cmd_t    cmd;
  pscf_status_t status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // register file, writes land on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SAMPLE_RATE_RST;
      decay_q       <= DECAY_RST;
      level_q       <= LEVEL_RST;
      amplitude_q   <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_SAMPLE_RATE: sample_rate_q <= pwdata[SR_W-1:0];
        REG_DECAY:       decay_q       <= pwdata[GAIN_W-1:0];
        REG_LEVEL:       level_q       <= pwdata[GAIN_W-1:0];
        REG_AMPLITUDE:   amplitude_q   <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_SAMPLE_RATE: prdata = 32'(sample_rate_q);
      REG_DECAY:       prdata = 32'(decay_q);
      REG_LEVEL:       prdata = 32'(level_q);
      REG_AMPLITUDE:   prdata = 32'(amplitude_q);
      default:         prdata = '0;
    endcase
  end

  // sequencer: decides op path, steps divider, fill and arithmetic
  pscf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_op_i   (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // datapath: divider, noise fill, delay memory, filter and gains
  pscf_dp #(
    .MAX_DELAY(MAX_DELAY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_rate_i(sample_rate_q),
    .decay_i      (decay_q),
    .level_i      (level_q),
    .amplitude_i  (amplitude_q),
    .excite_i     (s_axis_tdata[15:0]),
    .mix_i        (s_axis_tdata[31:16]),
    .freq_i       (s_axis_tdata[50:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_sample_o (m_axis_tdata)
  );

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !status.out_busy)
    else $error("output register overwritten while held");

  // memory writes and divider steps only happen with the input closed
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.div_step || cmd.fill_step || cmd.f4))
    else $error("datapath active while input open");

  // a result only appears after the sequencer loaded it
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a load");

endmodule

// File: verif/pscf_checker.sv
`timescale 1ns / 100ps

module pscf_checker
  import pscf_pkg::*;
#(
  parameter int unsigned DEPTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [55:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatches_o,
  output int          owed_o
);

  logic signed [15:0] delay_line [DEPTH];
  int unsigned        tap_index;
  int unsigned        loop_length;
  logic signed [15:0] prev_tap;
  logic [31:0]        noise_state;

  logic [SR_W-1:0]    rate_q;
  logic [GAIN_W-1:0]  decay_q;
  logic [GAIN_W-1:0]  level_q;
  logic [GAIN_W-1:0]  amp_q;

  logic signed [15:0] expected_samples [$];
  int                 mismatches = 0;

  function automatic logic signed [15:0] clip_q15(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // new delay length from the pitch, then noise into that many entries
  function automatic void pluck_string(input logic [18:0] freq);
    int unsigned len;
    if (freq == '0) begin
      len = DEPTH - 1;
    end else begin
      len = (32'(rate_q) << 4) / 32'(freq);
    end
    if (len >= DEPTH) len = DEPTH - 1;
    if (len < 1) len = 1;
    for (int unsigned i = 0; i < len; i++) begin
      noise_state = {1'b0, noise_state[31:1]} ^ (noise_state[0] ? LFSR_TAPS : 32'h0);
      delay_line[i] = noise_state[31:16];
    end
    loop_length = len;
    tap_index   = 0;
    prev_tap    = '0;
  endfunction

  // one pass around the loop, returns the mixed output sample
  function automatic logic signed [15:0] voice_sample(input logic signed [15:0] excite,
                                                      input logic signed [15:0] mix);
    longint tap;
    longint filt;
    longint fb;
    longint voice;
    tap  = delay_line[tap_index];
    filt = (longint'(W_DELAYED) * tap + longint'(W_PREV) * longint'(prev_tap) + 16384) >>> 15;
    fb   = ((filt + longint'(excite)) * longint'(decay_q) + 32768) >>> 16;
    delay_line[tap_index] = clip_q15(fb);
    tap_index++;
    if (tap_index >= loop_length) tap_index = 0;
    prev_tap = tap[15:0];
    voice = (filt * longint'(level_q) * longint'(amp_q) + (longint'(1) << 31)) >>> 32;
    return clip_q15(longint'(mix) + voice);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [15:0] want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < DEPTH; i++) delay_line[i] = '0;
      tap_index   = 0;
      loop_length = 1;
      prev_tap    = '0;
      noise_state = LFSR_SEED;
      rate_q      = SAMPLE_RATE_RST;
      decay_q     = DECAY_RST;
      level_q     = LEVEL_RST;
      amp_q       = AMPLITUDE_RST;
      expected_samples.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_SAMPLE_RATE: rate_q  = pwdata_i[SR_W-1:0];
          REG_DECAY:       decay_q = pwdata_i[GAIN_W-1:0];
          REG_LEVEL:       level_q = pwdata_i[GAIN_W-1:0];
          REG_AMPLITUDE:   amp_q   = pwdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: out_sample %0d arrived with no transaction pending",
                   $time, $signed(out_data_i));
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data_i !== want) begin
            $display("%0t: out_sample expected %0d actual %0d",
                     $time, want, $signed(out_data_i));
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_user_i == OP_PLUCK) begin
          pluck_string(in_data_i[50:32]);
        end else begin
          expected_samples.push_back(voice_sample(in_data_i[15:0], in_data_i[31:16]));
        end
      end
    end
    owed_o       <= expected_samples.size();
    mismatches_o <= mismatches;
  end

endmodule

// File: verif/tb_plucked_string_comb_filter.sv
`timescale 1ns / 100ps

module tb_plucked_string_comb_filter;
  import pscf_pkg::*;

  // clock, reset and all block inputs start at known values
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int results_owed;

  // set for the closing stretch: no gaps from the sender, no stalls from the sink
  bit steady = 1'b0;

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  plucked_string_comb_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // excite_in[15:0], mix_in[31:16], frequency_q4[50:32]
    .s_axis_tuser  (s_axis_tuser),   // op[0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_sample[15:0]
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // watches both streams and the register port, predicts and compares
  pscf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatch_count),
    .owed_o       (results_owed)
  );

  // offer one input transaction and hold it until the block takes it
  task automatic send_item(input logic op, input logic [15:0] excite,
                           input logic [15:0] mix, input logic [18:0] freq);
    int gap;
    // random gap before the transaction, so it lands on any phase of the block
    if (!steady && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, freq, mix, excite};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // setup cycle then access cycle; psel is left high so back-to-back
  // writes never assign it twice in one step
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // drain the block, then load all four registers
  task automatic reprogram(input logic [17:0] rate, input logic [15:0] dcy,
                           input logic [15:0] lvl, input logic [15:0] amp);
    logic [31:0] word;
    s_axis_tvalid <= 1'b0;
    // wait for every owed sample transaction to come back
    do @(posedge clk_i); while (results_owed != 0);
    // a pluck returns nothing and may still be filling: longest fill plus divide
    repeat (2100) @(posedge clk_i);
    // upper bits of the bus carry junk, only the register width counts
    word = $urandom();
    word[SR_W-1:0] = rate;
    apb_write(REG_SAMPLE_RATE, word);
    word = $urandom();
    word[GAIN_W-1:0] = dcy;
    apb_write(REG_DECAY, word);
    word = $urandom();
    word[GAIN_W-1:0] = lvl;
    apb_write(REG_LEVEL, word);
    word = $urandom();
    word[GAIN_W-1:0] = amp;
    apb_write(REG_AMPLITUDE, word);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly sample transactions, now and then a pluck with mostly short loops
  task automatic random_item();
    logic [15:0] excite;
    logic [18:0] freq;
    freq = 19'($urandom());
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 3) != 0) freq = 19'($urandom_range(2000, 384000));
      send_item(OP_PLUCK, 16'($urandom()), 16'($urandom()), freq);
    end else begin
      case ($urandom_range(0, 3))
        0: excite = '0;                                   // let the string ring down
        1: excite = 16'($urandom_range(0, 4000) - 2000);  // light excitation
        2: excite = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: excite = 16'($urandom());
      endcase
      send_item(OP_SAMPLE, excite, 16'($urandom()), freq);
    end
  endtask

  // sink side: random stall bursts, with quiet windows in between
  initial begin : sink
    int  hold;
    int  window;
    bit  allow;
    hold   = 0;
    window = 0;
    allow  = 1'b1;
    forever begin
      @(posedge clk_i);
      if (window == 0) begin
        allow  = ($urandom_range(0, 2) != 0);
        window = 120;
      end
      window--;
      if (hold > 0) begin
        hold--;
      end else if (allow && !steady && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(0, 17);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int ph;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full gains so the loop shows directly on the output
    reprogram(18'd44100, 16'hffff, 16'hffff, 16'hffff);
    // before any pluck the store reads zero and the loop length is one
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 19'd0);
    send_item(OP_SAMPLE, 16'h7fff, 16'h7fff, 19'h7ffff);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 19'd0);
    // saturated feedback drives the output into both rails
    send_item(OP_SAMPLE, 16'h7fff, 16'h7fff, 19'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 19'd0);
    // zero frequency gives the longest loop
    send_item(OP_PLUCK, 16'h1234, 16'h4321, 19'd0);
    send_item(OP_SAMPLE, 16'h0000, 16'h0100, 19'd0);
    send_item(OP_SAMPLE, 16'h7fff, 16'h8000, 19'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 19'd0);
    // top pitch gives a loop of one entry
    send_item(OP_PLUCK, 16'h0000, 16'h0000, 19'h7ffff);
    // a middle pitch, 440 Hz
    send_item(OP_PLUCK, 16'hffff, 16'hffff, 19'd7040);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 19'd0);
    send_item(OP_SAMPLE, 16'h0010, 16'hfff0, 19'd0);

    // everything at zero: a zero sample rate clamps the loop to one entry
    reprogram(18'd0, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_PLUCK, 16'h0000, 16'h0000, 19'd1000);
    send_item(OP_SAMPLE, 16'h7fff, 16'h8000, 19'd0);
    send_item(OP_PLUCK, 16'h0000, 16'h0000, 19'd0);
    send_item(OP_SAMPLE, 16'h8000, 16'h7fff, 19'd0);

    // largest rate: a low pitch overflows the store and clamps
    reprogram(18'h3ffff, 16'hffff, 16'hffff, 16'h8000);
    send_item(OP_PLUCK, 16'h0000, 16'h0000, 19'd1);
    send_item(OP_SAMPLE, 16'h4000, 16'hc000, 19'd0);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 19'd0);
    send_item(OP_PLUCK, 16'h0000, 16'h0000, 19'h7ffff);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 19'd0);

    // random phases, each with its own register setting
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: reprogram(18'h3ffff, 16'hffff, 16'hffff, 16'hffff);
        1: reprogram(18'd8000, 16'h0000, 16'hffff, 16'h0001);
        default: reprogram(18'($urandom_range(8000, 192000)),
                           16'($urandom_range(40000, 65535)),
                           16'($urandom_range(16384, 65535)),
                           16'($urandom_range(16384, 65535)));
      endcase
      repeat (40) random_item();
      // the sender holds off until every owed result is back
      if (ph == 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (results_owed != 0);
      end
      // closing stretch runs without gaps or stalls
      if (ph == 5) steady = 1'b1;
      repeat (32) random_item();
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (results_owed != 0);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("plucked_string_comb_filter: match");
    end else begin
      $display("plucked_string_comb_filter: mismatch");
    end
    $finish;
  end

  // hang guard, far above the longest expected run
  initial begin : watchdog
    #2_000_000;
    $display("plucked_string_comb_filter: mismatch");
    $finish;
  end

endmodule

// File: sim.f
design/pscf_pkg.sv
design/pscf_ram.sv
design/pscf_ctrl.sv
design/pscf_dp.sv
design/plucked_string_comb_filter.sv
verif/pscf_checker.sv
verif/tb_plucked_string_comb_filter.sv
